// ===== src/clock_divider_search_defines.svh =====
// ----------------------------------------------------------------------------
// Clock divider search assertion macros
// Shared assertion shorthands, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DIVIDER_SEARCH_DEFINES_SVH
`define CLOCK_DIVIDER_SEARCH_DEFINES_SVH

// same-cycle implication
`define CDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clock divider search check failed");

// next-cycle implication
`define CDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clock divider search check failed");

`endif

// ===== src/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock divider search package
// Widths and per-lane payload types shared by the pipeline modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  localparam int RATE_W  = 31;
  localparam int DIV_W   = 16;
  localparam int SHIFT_W = 4;
  localparam int WID_W   = 5;
  localparam int TWICE_W = 32;
  localparam int NUM1_W  = 33;
  localparam int Q1_W    = 17;
  localparam int Q2_W    = 32;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 88;

  // sideband of the first divide
  typedef struct packed {
    logic               ovf;
    logic               wz;
    logic [WID_W-1:0]   wcl;
    logic [RATE_W-1:0]  wanted;
    logic [TWICE_W-1:0] twice;
  } s1_t;

  // sideband of the second divide
  typedef struct packed {
    logic              rej;
    logic [RATE_W-1:0] wanted;
    logic [DIV_W-1:0]  div;
  } s2_t;

  typedef struct packed {
    logic               valid;
    logic [RATE_W-1:0]  err;
    logic [RATE_W-1:0]  rate;
    logic [DIV_W-1:0]   div;
    logic [SHIFT_W-1:0] shift;
  } cand_t;

endpackage

`default_nettype wire

// ===== src/cds_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, sideband travels with the data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cds_div_pipe #(
  parameter int NW = 33,
  parameter int DW = 31,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          ce_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic      [QW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  localparam int WW = NW + QW + DW;

  logic [NW-1:0] rem_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  assign rem_q[0]  = num_i;
  assign quo_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [WW-1:0] dsh;
    logic [WW-1:0] rext;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      dsh   = {{(WW-DW){1'b0}}, den_q[k]} << B;
      rext  = {{(WW-NW){1'b0}}, rem_q[k]};
      ge    = rext >= dsh;
      rem_d = ge ? (rem_q[k] - dsh[NW-1:0]) : rem_q[k];
      quo_d = quo_q[k] | ({{(QW-1){1'b0}}, ge} << B);
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k+1]  <= rem_d;
        quo_q[k+1]  <= quo_d;
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign quo_o  = quo_q[QW];
  assign side_o = side_q[QW];

endmodule

`default_nettype wire

// ===== src/cds_select.sv =====
// ----------------------------------------------------------------------------
// Candidate selection tree
// Registered pairwise minimum of shortfall, the lower shift wins a tie.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cds_select
  import cds_pkg::*;
#(
  parameter int N = 9
) (
  input  wire logic  clk_i,
  input  wire logic  ce_i,
  input  wire cand_t cand_i [N],
  output cand_t      best_o
);

  localparam int LV = (N <= 1) ? 1 : $clog2(N);
  localparam int PN = 1 << LV;

  cand_t node_q [LV+1][PN];

  for (genvar i = 0; i < PN; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node_q[0][i] = cand_i[i];
    end else begin : g_pad
      assign node_q[0][i] = '0;
    end
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar i = 0; i < PN; i++) begin : g_node
      if (i < (PN >> l)) begin : g_cmp
        cand_t a, b, pick;
        always_comb begin
          a = node_q[l-1][2*i];
          b = node_q[l-1][2*i+1];
          // later lane only wins on a strictly lower shortfall
          if (b.valid && (!a.valid || (b.err < a.err))) begin
            pick = b;
          end else begin
            pick = a;
          end
        end
        always_ff @(posedge clk_i) begin
          if (ce_i) begin
            node_q[l][i] <= pick;
          end
        end
      end else begin : g_idle
        assign node_q[l][i] = '0;
      end
    end
  end

  assign best_o = node_q[LV][0];

endmodule

`default_nettype wire

// ===== src/clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// Clock divider search
// Finds the best post-shift and N.1 fractional divider for a wanted rate.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis beat: parent rate, wanted rate and divider width (clamped to 16).
//   m_axis beat: found flag, divider, post shift, achieved rate, error.
//   one result beat per request beat, in order.
// Pipeline: input register, first divider, register, second divider,
//   candidate register and selection tree; one quotient bit per divider stage.
// Throughput: one beat per cycle when not stalled; every post shift has
//   its own lane of two pipelined dividers, and a registered tree picks the winner.
// Reset: clears the valid bits only; the pipeline comes up empty.
// Stall: while the output beat is held and not taken, the whole pipeline
//   freezes and s_axis_tready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_divider_search
  import cds_pkg::*;
#(
  parameter int MAX_POST_SHIFT = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // src_rate[30:0], wanted_rate[61:31], divider_width[66:62], zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // found[0], divider[16:1], post_shift[20:17], achieved_rate[51:21],
  // rate_error[82:52], zero pad
  output logic      [OUT_W-1:0] m_axis_tdata_o
);

`include "clock_divider_search_defines.svh"

  localparam int LANES = MAX_POST_SHIFT + 1;
  localparam int LV    = (LANES <= 1) ? 1 : $clog2(LANES);
  localparam int TOT   = 1 + Q1_W + 1 + Q2_W + 1 + LV;

  logic              ce;
  logic [TOT-1:0]    vld_q;
  logic [RATE_W-1:0] parent, wanted;
  logic [WID_W-1:0]  width, wcl;
  cand_t             cand_q [LANES];
  cand_t             best;

  assign ce              = m_axis_tready_i || !vld_q[TOT-1];
  assign s_axis_tready_o = ce;

  assign parent = s_axis_tdata_i[30:0];
  assign wanted = s_axis_tdata_i[61:31];
  assign width  = s_axis_tdata_i[66:62];
  assign wcl    = (width > WID_W'(16)) ? WID_W'(16) : width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[TOT-2:0], s_axis_tvalid_i};
    end
  end

  for (genvar s = 0; s < LANES; s++) begin : g_lane
    logic [TWICE_W-1:0] twice;
    logic [NUM1_W-1:0]  num1;
    s1_t                s1_d, s1_q, s1_o;
    logic [NUM1_W-1:0]  num1_q;
    logic [Q1_W-1:0]    d1;
    logic [Q1_W-1:0]    lim;
    logic [Q1_W-1:0]    dm2;
    s2_t                s2_d, s2_q, s2_o;
    logic [TWICE_W-1:0] twice_q;
    logic [Q1_W-1:0]    den2_q;
    logic [Q2_W-1:0]    q2;
    logic [RATE_W-1:0]  rate, err;
    cand_t              cand_d;

    always_comb begin
      twice = {parent >> s, 1'b0};
      num1  = {1'b0, twice} + {2'b00, wanted} - NUM1_W'(1);
      s1_d.ovf    = {15'd0, num1[NUM1_W-1:Q1_W]} >= wanted;
      s1_d.wz     = wanted == '0;
      s1_d.wcl    = wcl;
      s1_d.wanted = wanted;
      s1_d.twice  = twice;
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        num1_q <= num1;
        s1_q   <= s1_d;
      end
    end

    cds_div_pipe #(
      .NW(NUM1_W), .DW(RATE_W), .QW(Q1_W), .SW($bits(s1_t))
    ) u_div1 (
      .clk_i (clk_i),
      .ce_i  (ce),
      .num_i (num1_q),
      .den_i (s1_q.wanted),
      .side_i(s1_q),
      .quo_o (d1),
      .side_o(s1_o)
    );

    always_comb begin
      lim = Q1_W'(1) << s1_o.wcl;
      dm2 = d1 - Q1_W'(2);
      s2_d.rej    = s1_o.ovf || s1_o.wz || ((d1 >= Q1_W'(2)) && (dm2 >= lim));
      s2_d.wanted = s1_o.wanted;
      s2_d.div    = (d1 < Q1_W'(2)) ? '0 : dm2[DIV_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        s2_q    <= s2_d;
        twice_q <= s1_o.twice;
        den2_q  <= {1'b0, s2_d.div} + Q1_W'(2);
      end
    end

    cds_div_pipe #(
      .NW(TWICE_W), .DW(Q1_W), .QW(Q2_W), .SW($bits(s2_t))
    ) u_div2 (
      .clk_i (clk_i),
      .ce_i  (ce),
      .num_i (twice_q),
      .den_i (den2_q),
      .side_i(s2_q),
      .quo_o (q2),
      .side_o(s2_o)
    );

    always_comb begin
      rate = q2[RATE_W-1:0];
      err  = (rate >= s2_o.wanted) ? '0 : (s2_o.wanted - rate);
      cand_d.valid = !s2_o.rej && (err < s2_o.wanted);
      cand_d.err   = err;
      cand_d.rate  = rate;
      cand_d.div   = s2_o.div;
      cand_d.shift = SHIFT_W'(s);
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        cand_q[s] <= cand_d;
      end
    end
  end

  cds_select #(.N(LANES)) u_select (
    .clk_i (clk_i),
    .ce_i  (ce),
    .cand_i(cand_q),
    .best_o(best)
  );

  assign m_axis_tvalid_o = vld_q[TOT-1];
  assign m_axis_tdata_o  = {5'd0,
                            best.valid ? best.err   : {RATE_W{1'b0}},
                            best.valid ? best.rate  : {RATE_W{1'b0}},
                            best.valid ? best.shift : {SHIFT_W{1'b0}},
                            best.valid ? best.div   : {DIV_W{1'b0}},
                            best.valid};

  `CDS_ASSERT_IMP(a_nf_zero, m_axis_tvalid_o && !m_axis_tdata_o[0], m_axis_tdata_o[82:1] == '0)
  `CDS_ASSERT_IMP(a_shift_rng, m_axis_tvalid_o && m_axis_tdata_o[0], m_axis_tdata_o[20:17] <= MAX_POST_SHIFT)
  `CDS_ASSERT_IMP(a_ready, 1'b1, s_axis_tready_o == (m_axis_tready_i || !m_axis_tvalid_o))
  `CDS_ASSERT_NXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

endmodule

`default_nettype wire
